>>> hdl/vasl_pkg.sv
// Shared types, command codes and widths for the vector speed limiter.
package vasl_pkg;

    localparam int CmdW = 5;
    typedef logic [CmdW-1:0] vasl_cmd_t;

    // Datapath commands issued by the controller
    localparam vasl_cmd_t CMD_NONE   = 5'd0;
    localparam vasl_cmd_t CMD_LOAD   = 5'd1;
    localparam vasl_cmd_t CMD_LIM    = 5'd2;
    localparam vasl_cmd_t CMD_DSQX   = 5'd3;
    localparam vasl_cmd_t CMD_DSQY   = 5'd4;
    localparam vasl_cmd_t CMD_DCMP   = 5'd5;
    localparam vasl_cmd_t CMD_ROOT   = 5'd6;
    localparam vasl_cmd_t CMD_DIV_DX = 5'd7;
    localparam vasl_cmd_t CMD_DQX    = 5'd8;
    localparam vasl_cmd_t CMD_DIV_DY = 5'd9;
    localparam vasl_cmd_t CMD_DQY    = 5'd10;
    localparam vasl_cmd_t CMD_VUPD   = 5'd11;
    localparam vasl_cmd_t CMD_VSQX   = 5'd12;
    localparam vasl_cmd_t CMD_VSQY   = 5'd13;
    localparam vasl_cmd_t CMD_VCMP   = 5'd14;
    localparam vasl_cmd_t CMD_DIV_SX = 5'd15;
    localparam vasl_cmd_t CMD_SQX    = 5'd16;
    localparam vasl_cmd_t CMD_DIV_SY = 5'd17;
    localparam vasl_cmd_t CMD_SQY    = 5'd18;
    localparam vasl_cmd_t CMD_PMX    = 5'd19;
    localparam vasl_cmd_t CMD_PAX    = 5'd20;
    localparam vasl_cmd_t CMD_PMY    = 5'd21;
    localparam vasl_cmd_t CMD_PAY    = 5'd22;
    localparam vasl_cmd_t CMD_DIV_AX = 5'd23;
    localparam vasl_cmd_t CMD_AQX    = 5'd24;
    localparam vasl_cmd_t CMD_DIV_AY = 5'd25;
    localparam vasl_cmd_t CMD_AQY    = 5'd26;
    localparam vasl_cmd_t CMD_OUT    = 5'd27;

    // Configuration register indexes
    localparam logic [1:0] REG_ACCEL = 2'd0;
    localparam logic [1:0] REG_SPEED = 2'd1;
    localparam logic [1:0] REG_STEP  = 2'd2;

    localparam logic [15:0] ACCEL_RESET = 16'd768;
    localparam logic [14:0] SPEED_RESET = 15'd1024;
    localparam logic [15:0] STEP_RESET  = 16'd6554;

    // Command kinds; the two spare codes behave like "none"
    localparam logic [2:0] OP_VELOCITY = 3'd0;
    localparam logic [2:0] OP_RETURN   = 3'd1;
    localparam logic [2:0] OP_LOITER   = 3'd2;
    localparam logic [2:0] OP_LAND     = 3'd3;
    localparam logic [2:0] OP_TAKEOFF  = 3'd4;
    localparam logic [2:0] OP_NONE     = 3'd5;
    localparam logic [2:0] OP_SPARE_A  = 3'd6;
    localparam logic [2:0] OP_SPARE_B  = 3'd7;

    // Status from datapath to controller
    typedef struct packed {
        logic cmp_gt;
        logic root_done;
        logic div_done;
    } vasl_status_t;

endpackage

>>> hdl/vector_accel_speed_limiter_top.sv
// Top level of the vector acceleration and speed limiter.
//
// Takes one command per transfer, limits the velocity change to
// accel_limit * step_time in vector magnitude, clamps speed to speed_limit,
// integrates position and reports velocity, position and acceleration. The
// time per item is set by the shared divider (one quotient bit per cycle,
// two to six divides per item) and the square-root unit (two bits per
// cycle); each limit that engages adds a root and two divides. A new
// command is taken only after the previous one has reached the output
// register, which holds its result until its transfer while the next
// command is already at work.
module vector_accel_speed_limiter_top
    import vasl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         op,
    input  logic signed [15:0] target_vx,
    input  logic signed [15:0] target_vy,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] vel_x_out,
    output logic signed [15:0] vel_y_out,
    output logic signed [31:0] pos_x_out,
    output logic signed [31:0] pos_y_out,
    output logic signed [15:0] acc_x_out,
    output logic signed [15:0] acc_y_out
);

    vasl_cmd_t    cmd;
    vasl_status_t status;

    vasl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    vasl_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .op        (op),
        .target_vx (target_vx),
        .target_vy (target_vy),
        .vel_x_out (vel_x_out),
        .vel_y_out (vel_y_out),
        .pos_x_out (pos_x_out),
        .pos_y_out (pos_y_out),
        .acc_x_out (acc_x_out),
        .acc_y_out (acc_y_out)
    );

endmodule

>>> hdl/vasl_sqrt.sv
// Iterative integer square root, two radicand bits per cycle.
module vasl_sqrt
    import vasl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [33:0] radicand,
    output logic [16:0] root,
    output logic        done
);

    logic [33:0] x_reg, x_next;
    logic [20:0] rem_reg, rem_next;
    logic [16:0] root_reg, root_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [20:0] shifted;
    logic [20:0] trial;

    // One digit step: bring down two bits, try root*4+1
    always_comb
    begin
        shifted   = {rem_reg[18:0], x_reg[33:32]};
        trial     = {2'b00, root_reg, 2'b01};
        x_next    = x_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_next    = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = 5'd16;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            x_next = {x_reg[31:0], 2'b00};
            if (shifted >= trial)
            begin
                rem_next  = shifted - trial;
                root_next = {root_reg[15:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted;
                root_next = {root_reg[15:0], 1'b0};
            end
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

>>> hdl/vasl_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module vasl_div
    import vasl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [16:0] den,
    output logic [31:0] quot,
    output logic        done
);

    logic [31:0] n_reg, n_next;
    logic [31:0] q_reg, q_next;
    logic [16:0] rem_reg, rem_next;
    logic [16:0] den_reg, den_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [17:0] shifted;
    logic [17:0] diff;

    // Shift in one numerator bit, subtract when it fits
    always_comb
    begin
        shifted   = {rem_reg, n_reg[31]};
        diff      = shifted - {1'b0, den_reg};
        n_next    = n_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            n_next    = num;
            q_next    = '0;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = 5'd31;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            n_next = {n_reg[30:0], 1'b0};
            if (shifted >= {1'b0, den_reg})
            begin
                rem_next = diff[16:0];
                q_next   = {q_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[16:0];
                q_next   = {q_reg[30:0], 1'b0};
            end
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quot = q_reg;
    assign done = done_reg;

endmodule

>>> hdl/vasl_datapath.sv
// Datapath: state, configuration, shared multiplier, root and divide units.
module vasl_datapath
    import vasl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  vasl_cmd_t          cmd,
    output vasl_status_t       status,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic [2:0]         op,
    input  logic signed [15:0] target_vx,
    input  logic signed [15:0] target_vy,
    output logic signed [15:0] vel_x_out,
    output logic signed [15:0] vel_y_out,
    output logic signed [31:0] pos_x_out,
    output logic signed [31:0] pos_y_out,
    output logic signed [15:0] acc_x_out,
    output logic signed [15:0] acc_y_out
);

    logic [15:0] accel_reg;
    logic [14:0] speed_reg;
    logic [15:0] step_reg;

    logic signed [15:0] vel_x_reg, vel_y_reg;
    logic signed [31:0] pos_x_reg, pos_y_reg;
    logic signed [16:0] d_x_reg, d_y_reg;
    logic [15:0]        lim_reg;
    logic [33:0]        sum_reg;
    logic               cmp_reg;
    logic signed [35:0] prod_reg;
    logic signed [15:0] acc_x_reg, acc_y_reg;
    logic signed [15:0] ovx_reg, ovy_reg, oax_reg, oay_reg;
    logic signed [31:0] opx_reg, opy_reg;

    logic signed [17:0] mul_a, mul_b;
    logic signed [35:0] prod;
    logic [15:0]        mag_dx, mag_dy, mag_vx, mag_vy;
    logic signed [16:0] neg_dx, neg_dy, neg_vx, neg_vy;
    logic               take_target;
    logic signed [16:0] tx, ty;
    logic [32:0]        lim_round;

    logic        root_start, root_done;
    logic [16:0] root;
    logic        div_start, div_done;
    logic [31:0] div_num, quot;
    logic [16:0] div_den;

    logic signed [35:0] pstep;
    logic signed [33:0] pos_sum;
    logic signed [31:0] pos_sat;
    logic signed [31:0] pos_sel;
    logic signed [15:0] acc_sat;
    logic               acc_neg;
    logic signed [16:0] qd;
    logic signed [15:0] qv;

    // Magnitudes of the change and of the velocity
    assign neg_dx = -d_x_reg;
    assign neg_dy = -d_y_reg;
    assign neg_vx = -{vel_x_reg[15], vel_x_reg};
    assign neg_vy = -{vel_y_reg[15], vel_y_reg};
    assign mag_dx = d_x_reg[16] ? neg_dx[15:0] : d_x_reg[15:0];
    assign mag_dy = d_y_reg[16] ? neg_dy[15:0] : d_y_reg[15:0];
    assign mag_vx = vel_x_reg[15] ? neg_vx[15:0] : vel_x_reg;
    assign mag_vy = vel_y_reg[15] ? neg_vy[15:0] : vel_y_reg;

    // Select multiplier operands per command
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd)
            CMD_LIM:    begin mul_a = {2'b00, accel_reg}; mul_b = {2'b00, step_reg}; end
            CMD_DSQX:   begin mul_a = {2'b00, mag_dx};    mul_b = {2'b00, mag_dx};   end
            CMD_DSQY:   begin mul_a = {2'b00, mag_dy};    mul_b = {2'b00, mag_dy};   end
            CMD_DCMP:   begin mul_a = {2'b00, lim_reg};   mul_b = {2'b00, lim_reg};  end
            CMD_DIV_DX: begin mul_a = {2'b00, mag_dx};    mul_b = {2'b00, lim_reg};  end
            CMD_DIV_DY: begin mul_a = {2'b00, mag_dy};    mul_b = {2'b00, lim_reg};  end
            CMD_VSQX:   begin mul_a = {2'b00, mag_vx};    mul_b = {2'b00, mag_vx};   end
            CMD_VSQY:   begin mul_a = {2'b00, mag_vy};    mul_b = {2'b00, mag_vy};   end
            CMD_VCMP:   begin mul_a = {3'b000, speed_reg}; mul_b = {3'b000, speed_reg}; end
            CMD_DIV_SX: begin mul_a = {2'b00, mag_vx};    mul_b = {3'b000, speed_reg}; end
            CMD_DIV_SY: begin mul_a = {2'b00, mag_vy};    mul_b = {3'b000, speed_reg}; end
            CMD_PMX:    begin mul_a = {{2{vel_x_reg[15]}}, vel_x_reg};
                              mul_b = {2'b00, step_reg}; end
            CMD_PMY:    begin mul_a = {{2{vel_y_reg[15]}}, vel_y_reg};
                              mul_b = {2'b00, step_reg}; end
            default:    begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign prod = mul_a * mul_b;

    // Start the shared units
    assign root_start = (cmd == CMD_ROOT);
    assign div_start  = (cmd == CMD_DIV_DX) || (cmd == CMD_DIV_DY) ||
                        (cmd == CMD_DIV_SX) || (cmd == CMD_DIV_SY) ||
                        (cmd == CMD_DIV_AX) || (cmd == CMD_DIV_AY);

    always_comb
    begin
        div_num = prod[31:0];
        div_den = root;
        if (cmd == CMD_DIV_AX)
        begin
            div_num = {mag_dx, 16'h0000};
            div_den = {1'b0, step_reg};
        end
        else if (cmd == CMD_DIV_AY)
        begin
            div_num = {mag_dy, 16'h0000};
            div_den = {1'b0, step_reg};
        end
    end

    vasl_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (sum_reg),
        .root     (root),
        .done     (root_done)
    );

    vasl_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .quot  (quot),
        .done  (div_done)
    );

    // Target selection and rounded change limit
    assign take_target = (op == OP_VELOCITY) || (op == OP_RETURN);
    assign tx = take_target ? {target_vx[15], target_vx} : 17'sd0;
    assign ty = take_target ? {target_vy[15], target_vy} : 17'sd0;
    assign lim_round = {1'b0, prod[31:0]} + 33'd32768;

    // Signed quotients for change and velocity write-back
    always_comb
    begin
        qd = {1'b0, quot[15:0]};
        qv = quot[15:0];
        if (((cmd == CMD_DQX) && d_x_reg[16]) || ((cmd == CMD_DQY) && d_y_reg[16]))
        begin
            qd = -{1'b0, quot[15:0]};
        end
        if (((cmd == CMD_SQX) && vel_x_reg[15]) || ((cmd == CMD_SQY) && vel_y_reg[15]))
        begin
            qv = -quot[15:0];
        end
    end

    // Saturated acceleration from the divider result
    always_comb
    begin
        acc_neg = (cmd == CMD_AQX) ? d_x_reg[16] : d_y_reg[16];
        if (step_reg == 16'd0)
        begin
            acc_sat = 16'sd0;
        end
        else if (acc_neg)
        begin
            acc_sat = (quot > 32'd32768) ? 16'sh8000 : -quot[15:0];
        end
        else
        begin
            acc_sat = (quot > 32'd32767) ? 16'sh7FFF : quot[15:0];
        end
    end

    // Position step with rounding and saturation
    always_comb
    begin
        pos_sel = (cmd == CMD_PAX) ? pos_x_reg : pos_y_reg;
        pstep   = (prod_reg + 36'sd128) >>> 8;
        pos_sum = {{2{pos_sel[31]}}, pos_sel} + pstep[33:0];
        if (pos_sum > 34'sd2147483647)
        begin
            pos_sat = 32'h7FFFFFFF;
        end
        else if (pos_sum < -34'sd2147483648)
        begin
            pos_sat = 32'h80000000;
        end
        else
        begin
            pos_sat = pos_sum[31:0];
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_reg <= ACCEL_RESET;
            speed_reg <= SPEED_RESET;
            step_reg  <= STEP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ACCEL: accel_reg <= cfg_data;
                REG_SPEED: speed_reg <= cfg_data[14:0];
                REG_STEP:  step_reg  <= cfg_data;
                default:   ;
            endcase
        end
    end

    // Vehicle state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vel_x_reg <= '0;
            vel_y_reg <= '0;
            pos_x_reg <= '0;
            pos_y_reg <= '0;
        end
        else
        begin
            unique case (cmd)
                CMD_VUPD:
                begin
                    vel_x_reg <= vel_x_reg + d_x_reg[15:0];
                    vel_y_reg <= vel_y_reg + d_y_reg[15:0];
                end
                CMD_SQX: vel_x_reg <= qv;
                CMD_SQY: vel_y_reg <= qv;
                CMD_PAX: pos_x_reg <= pos_sat;
                CMD_PAY: pos_y_reg <= pos_sat;
                default: ;
            endcase
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        unique case (cmd)
            CMD_LOAD:
            begin
                d_x_reg <= tx - {vel_x_reg[15], vel_x_reg};
                d_y_reg <= ty - {vel_y_reg[15], vel_y_reg};
            end
            CMD_LIM:  lim_reg <= lim_round[31:16];
            CMD_DSQX: sum_reg <= {2'b00, prod[31:0]};
            CMD_DSQY: sum_reg <= sum_reg + {2'b00, prod[31:0]};
            CMD_DCMP: cmp_reg <= sum_reg > {2'b00, prod[31:0]};
            CMD_DQX:  d_x_reg <= qd;
            CMD_DQY:  d_y_reg <= qd;
            CMD_VSQX: sum_reg <= {2'b00, prod[31:0]};
            CMD_VSQY: sum_reg <= sum_reg + {2'b00, prod[31:0]};
            CMD_VCMP: cmp_reg <= sum_reg > {2'b00, prod[31:0]};
            CMD_PMX:  prod_reg <= prod;
            CMD_PMY:  prod_reg <= prod;
            CMD_AQX:  acc_x_reg <= acc_sat;
            CMD_AQY:  acc_y_reg <= acc_sat;
            CMD_OUT:
            begin
                ovx_reg <= vel_x_reg;
                ovy_reg <= vel_y_reg;
                opx_reg <= pos_x_reg;
                opy_reg <= pos_y_reg;
                oax_reg <= acc_x_reg;
                oay_reg <= acc_y_reg;
            end
            default: ;
        endcase
    end

    assign status.cmp_gt    = cmp_reg;
    assign status.root_done = root_done;
    assign status.div_done  = div_done;

    assign vel_x_out = ovx_reg;
    assign vel_y_out = ovy_reg;
    assign pos_x_out = opx_reg;
    assign pos_y_out = opy_reg;
    assign acc_x_out = oax_reg;
    assign acc_y_out = oay_reg;

endmodule

>>> hdl/vasl_ctrl.sv
// Controller: sequences datapath commands and runs both handshakes.
module vasl_ctrl
    import vasl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  vasl_status_t status,
    output vasl_cmd_t    cmd
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_LIM   = 5'd1;
    localparam logic [4:0] S_DSQX  = 5'd2;
    localparam logic [4:0] S_DSQY  = 5'd3;
    localparam logic [4:0] S_DCMP  = 5'd4;
    localparam logic [4:0] S_DROOT = 5'd5;
    localparam logic [4:0] S_DRW   = 5'd6;
    localparam logic [4:0] S_DDX   = 5'd7;
    localparam logic [4:0] S_DWX   = 5'd8;
    localparam logic [4:0] S_DDY   = 5'd9;
    localparam logic [4:0] S_DWY   = 5'd10;
    localparam logic [4:0] S_VUPD  = 5'd11;
    localparam logic [4:0] S_VSQX  = 5'd12;
    localparam logic [4:0] S_VSQY  = 5'd13;
    localparam logic [4:0] S_VCMP  = 5'd14;
    localparam logic [4:0] S_SROOT = 5'd15;
    localparam logic [4:0] S_SRW   = 5'd16;
    localparam logic [4:0] S_SDX   = 5'd17;
    localparam logic [4:0] S_SWX   = 5'd18;
    localparam logic [4:0] S_SDY   = 5'd19;
    localparam logic [4:0] S_SWY   = 5'd20;
    localparam logic [4:0] S_PMX   = 5'd21;
    localparam logic [4:0] S_PAX   = 5'd22;
    localparam logic [4:0] S_PMY   = 5'd23;
    localparam logic [4:0] S_PAY   = 5'd24;
    localparam logic [4:0] S_ADX   = 5'd25;
    localparam logic [4:0] S_AWX   = 5'd26;
    localparam logic [4:0] S_ADY   = 5'd27;
    localparam logic [4:0] S_AWY   = 5'd28;
    localparam logic [4:0] S_OUT   = 5'd29;

    logic [4:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    // Next state and command
    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd        = CMD_LOAD;
                    state_next = S_LIM;
                end
            end
            S_LIM:  begin cmd = CMD_LIM;  state_next = S_DSQX; end
            S_DSQX: begin cmd = CMD_DSQX; state_next = S_DSQY; end
            S_DSQY: begin cmd = CMD_DSQY; state_next = S_DCMP; end
            S_DCMP: begin cmd = CMD_DCMP; state_next = S_DROOT; end
            S_DROOT:
            begin
                if (status.cmp_gt)
                begin
                    cmd        = CMD_ROOT;
                    state_next = S_DRW;
                end
                else
                begin
                    state_next = S_VUPD;
                end
            end
            S_DRW:  if (status.root_done) state_next = S_DDX;
            S_DDX:  begin cmd = CMD_DIV_DX; state_next = S_DWX; end
            S_DWX:
            begin
                if (status.div_done)
                begin
                    cmd        = CMD_DQX;
                    state_next = S_DDY;
                end
            end
            S_DDY:  begin cmd = CMD_DIV_DY; state_next = S_DWY; end
            S_DWY:
            begin
                if (status.div_done)
                begin
                    cmd        = CMD_DQY;
                    state_next = S_VUPD;
                end
            end
            S_VUPD: begin cmd = CMD_VUPD; state_next = S_VSQX; end
            S_VSQX: begin cmd = CMD_VSQX; state_next = S_VSQY; end
            S_VSQY: begin cmd = CMD_VSQY; state_next = S_VCMP; end
            S_VCMP: begin cmd = CMD_VCMP; state_next = S_SROOT; end
            S_SROOT:
            begin
                if (status.cmp_gt)
                begin
                    cmd        = CMD_ROOT;
                    state_next = S_SRW;
                end
                else
                begin
                    state_next = S_PMX;
                end
            end
            S_SRW:  if (status.root_done) state_next = S_SDX;
            S_SDX:  begin cmd = CMD_DIV_SX; state_next = S_SWX; end
            S_SWX:
            begin
                if (status.div_done)
                begin
                    cmd        = CMD_SQX;
                    state_next = S_SDY;
                end
            end
            S_SDY:  begin cmd = CMD_DIV_SY; state_next = S_SWY; end
            S_SWY:
            begin
                if (status.div_done)
                begin
                    cmd        = CMD_SQY;
                    state_next = S_PMX;
                end
            end
            S_PMX:  begin cmd = CMD_PMX; state_next = S_PAX; end
            S_PAX:  begin cmd = CMD_PAX; state_next = S_PMY; end
            S_PMY:  begin cmd = CMD_PMY; state_next = S_PAY; end
            S_PAY:  begin cmd = CMD_PAY; state_next = S_ADX; end
            S_ADX:  begin cmd = CMD_DIV_AX; state_next = S_AWX; end
            S_AWX:
            begin
                if (status.div_done)
                begin
                    cmd        = CMD_AQX;
                    state_next = S_ADY;
                end
            end
            S_ADY:  begin cmd = CMD_DIV_AY; state_next = S_AWY; end
            S_AWY:
            begin
                if (status.div_done)
                begin
                    cmd        = CMD_AQY;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd        = CMD_OUT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Hold the result until its transfer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd == CMD_OUT)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

>>> hdl/vasl_checker.sv
// Port-level checker for the limiter top level and its bind.
module vasl_checker
    import vasl_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] vel_x_out,
    input logic signed [31:0] pos_x_out
);

    // One command at a time: ready drops after a transfer
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a command is at work");

    // A fresh result appears only as the block turns idle
    a_result_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result appeared while still busy");

    // A stalled result keeps its payload
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(vel_x_out) && $stable(pos_x_out))
        else $error("stalled result changed");

endmodule

bind vector_accel_speed_limiter_top vasl_checker u_vasl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .vel_x_out (vel_x_out),
    .pos_x_out (pos_x_out)
);

>>> bench/tb_vector_accel_speed_limiter_top.sv
// Testbench for the vector acceleration and speed limiter: directed, back-pressure and random commands.
`timescale 1ns / 100ps

module tb_vector_accel_speed_limiter_top;
    import vasl_pkg::*;

    typedef struct {
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
    } motion_t;

    localparam int StallLimit = 20000;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [2:0]         op;
    logic signed [15:0] target_vx;
    logic signed [15:0] target_vy;
    logic               out_valid;
    logic               out_ready;
    logic signed [15:0] vel_x_out;
    logic signed [15:0] vel_y_out;
    logic signed [31:0] pos_x_out;
    logic signed [31:0] pos_y_out;
    logic signed [15:0] acc_x_out;
    logic signed [15:0] acc_y_out;

    // predictor state and registers
    longint m_accel, m_speed, m_step;
    longint m_vx, m_vy, m_px, m_py;
    motion_t pending_motion[$];
    int error_count;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_off_cycles;
    int quiet_cycles;

    vector_accel_speed_limiter_top i_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint isqrt(longint x);
        longint r;
        longint b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > x) b = b >>> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >>> 1) + b;
            end
            else
                r = r >>> 1;
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic longint scale_trunc(longint v, longint num, longint den);
        longint q;
        q = ((v < 0) ? -v : v) * num / den;
        return (v < 0) ? -q : q;
    endfunction

    function automatic longint sat(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint pos_delta(longint v);
        longint p;
        p = v * m_step + 128;
        return (p >= 0) ? (p / 256) : -((-p + 255) / 256);
    endfunction

    // advance the motion state by one command and return the expected output
    function automatic motion_t track_command(logic [2:0] cmd, logic signed [15:0] tx,
                                              logic signed [15:0] ty);
        longint gx, gy, dx, dy, lim, n;
        motion_t r;
        gx = 0;
        gy = 0;
        if (cmd == OP_VELOCITY || cmd == OP_RETURN)
        begin
            gx = tx;
            gy = ty;
        end
        dx = gx - m_vx;
        dy = gy - m_vy;
        lim = (m_accel * m_step + 32768) >>> 16;
        if (dx * dx + dy * dy > lim * lim)
        begin
            n = isqrt(dx * dx + dy * dy);
            dx = scale_trunc(dx, lim, n);
            dy = scale_trunc(dy, lim, n);
        end
        m_vx = m_vx + dx;
        m_vy = m_vy + dy;
        if (m_vx * m_vx + m_vy * m_vy > m_speed * m_speed)
        begin
            n = isqrt(m_vx * m_vx + m_vy * m_vy);
            m_vx = scale_trunc(m_vx, m_speed, n);
            m_vy = scale_trunc(m_vy, m_speed, n);
        end
        m_px = sat(m_px + pos_delta(m_vx), -64'sd2147483648, 64'sd2147483647);
        m_py = sat(m_py + pos_delta(m_vy), -64'sd2147483648, 64'sd2147483647);
        r.vx = m_vx[15:0];
        r.vy = m_vy[15:0];
        r.px = m_px[31:0];
        r.py = m_py[31:0];
        r.ax = 16'sd0;
        r.ay = 16'sd0;
        if (m_step != 0)
        begin
            r.ax = 16'(sat(scale_trunc(dx, 65536, m_step), -32768, 32767));
            r.ay = 16'(sat(scale_trunc(dy, 65536, m_step), -32768, 32767));
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // offer one command and hold it until its transfer
    task automatic send_command(logic [2:0] cmd, logic signed [15:0] tx, logic signed [15:0] ty);
        while ($urandom_range(99) < send_idle_pct) @(negedge clk);
        in_valid  <= 1'b1;
        op        <= cmd;
        target_vx <= tx;
        target_vy <= ty;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_motion.push_back(track_command(cmd, tx, ty));
        @(negedge clk);
        in_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_ACCEL) m_accel = val;
        else if (idx == REG_SPEED) m_speed = val[14:0];
        else m_step = val;
        @(negedge clk);
    endtask

    task automatic drain;
        while (pending_motion.size() != 0) @(negedge clk);
        repeat (250) @(negedge clk);
    endtask

    task automatic set_limits(logic [15:0] acc, logic [15:0] spd, logic [15:0] stp);
        drain();
        write_reg(REG_ACCEL, acc);
        write_reg(REG_SPEED, spd);
        write_reg(REG_STEP, stp);
    endtask

    function automatic logic signed [15:0] rand_vel(int spread);
        if (spread == 0) return 16'($urandom);
        return $signed(16'($urandom_range(2 * spread))) - 16'(spread);
    endfunction

    task automatic test_directed;
        send_command(OP_VELOCITY, 16'sh7fff, 16'sh7fff);
        send_command(OP_VELOCITY, -16'sh8000, -16'sh8000);
        send_command(OP_RETURN, 16'sd300, -16'sd200);
        send_command(OP_LOITER, 16'sh7fff, 16'sd5);
        send_command(OP_LAND, 16'sd1, 16'sd1);
        send_command(OP_TAKEOFF, -16'sd1, 16'sd0);
        send_command(OP_NONE, 16'sd100, 16'sd100);
        send_command(OP_SPARE_A, 16'sd100, 16'sd100);
        send_command(OP_SPARE_B, -16'sd100, 16'sd100);
        send_command(OP_VELOCITY, 16'sd0, 16'sd0);
        set_limits(16'hffff, 16'h7fff, 16'hffff);
        send_command(OP_VELOCITY, 16'sh7fff, -16'sh8000);
        send_command(OP_VELOCITY, -16'sh8000, 16'sh7fff);
        send_command(OP_RETURN, 16'sh5555, -16'sh2aaa);
        set_limits(16'd0, 16'd0, 16'd0);
        send_command(OP_VELOCITY, 16'sd500, 16'sd500);
        set_limits(16'd20000, 16'd0, 16'd1);
        send_command(OP_VELOCITY, 16'sd500, -16'sd500);
        set_limits(16'hffff, 16'd3000, 16'd0);
        send_command(OP_VELOCITY, 16'sd500, -16'sd500);
    endtask

    task automatic random_phase(int count, int idle, int stall);
        int spread;
        logic [2:0] cmd;
        drain();
        send_idle_pct = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < count; i++)
        begin
            spread = ($urandom_range(3) == 0) ? 0 : 2000;
            cmd = ($urandom_range(2) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(1));
            send_command(cmd, rand_vel(spread), rand_vel(spread));
        end
    endtask

    task automatic test_random;
        set_limits(ACCEL_RESET, 16'(SPEED_RESET), STEP_RESET);
        random_phase(400, 0, 0);
        set_limits(16'($urandom), 16'($urandom_range(32767)), 16'($urandom_range(65535, 1)));
        random_phase(300, 88, 0);
        set_limits(16'($urandom_range(4000)), 16'($urandom_range(8000)), 16'($urandom_range(20000, 1)));
        random_phase(300, 0, 88);
        set_limits(16'hffff, 16'h7fff, 16'hffff);
        random_phase(300, 35, 35);
        set_limits(16'd1, 16'd1, 16'd1);
        random_phase(200, 35, 35);
        set_limits(16'($urandom), 16'($urandom_range(32767)), 16'($urandom_range(65535, 1)));
        random_phase(500, 0, 0);
    endtask

    // hold off the receiver while commands keep coming so the input stalls
    task automatic test_backpressure;
        drain();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 2000;
        repeat (6) send_command(OP_VELOCITY, rand_vel(3000), rand_vel(3000));
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        op = '0;
        target_vx = '0;
        target_vy = '0;
        error_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        m_accel = ACCEL_RESET;
        m_speed = SPEED_RESET;
        m_step = STEP_RESET;
        m_vx = 0;
        m_vy = 0;
        m_px = 0;
        m_py = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_backpressure();
        test_random();
        drain();
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // drive out_ready, with an optional long hold-off
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                out_ready <= 1'b0;
                hold_off_cycles--;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        motion_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_motion.size() == 0)
            begin
                report_mismatch("unexpected result transfers", 1, 0);
            end
            else
            begin
                w = pending_motion.pop_front();
                if (vel_x_out !== w.vx) report_mismatch("vel_x", vel_x_out, w.vx);
                if (vel_y_out !== w.vy) report_mismatch("vel_y", vel_y_out, w.vy);
                if (pos_x_out !== w.px) report_mismatch("pos_x", pos_x_out, w.px);
                if (pos_y_out !== w.py) report_mismatch("pos_y", pos_y_out, w.py);
                if (acc_x_out !== w.ax) report_mismatch("acc_x", acc_x_out, w.ax);
                if (acc_y_out !== w.ay) report_mismatch("acc_y", acc_y_out, w.ay);
            end
        end
    end

    // end the run when nothing transfers for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || pending_motion.size() == 0
            || hold_off_cycles > 0)
            quiet_cycles <= 0;
        else if (quiet_cycles >= StallLimit)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule
